>>> src/quaternion_slerp_core_assert.svh
// assertion macros for the quaternion slerp core
// used by the top level only, needs clock and reset names passed in
`ifndef QUATERNION_SLERP_CORE_ASSERT_SVH
`define QUATERNION_SLERP_CORE_ASSERT_SVH

// same-cycle implication
`define QSC_ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define QSC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> src/qslerp_pkg.sv
// shared types, constants and the arctangent table for the slerp core
// no dependencies
`default_nettype none

package qslerp_pkg;

   // pipeline segment lengths
   localparam int ISQRT_LAT  = 31;
   localparam int VEC_STEPS  = 30;
   localparam int SIN_STEPS  = 30;
   localparam int SIN_LAT    = SIN_STEPS + 1;
   localparam int DIV_STEPS  = 46;
   localparam int DIV_LAT    = DIV_STEPS + 2;

   // register positions along the pipeline (0 = first stage)
   localparam int POS_SQRT_OUT = 2 + ISQRT_LAT;
   localparam int POS_VEC_OUT  = POS_SQRT_OUT + VEC_STEPS;
   localparam int POS_ANG      = POS_VEC_OUT + 1;
   localparam int POS_SIN_OUT  = POS_ANG + SIN_LAT;
   localparam int POS_DIV_OUT  = POS_SIN_OUT + DIV_LAT;
   localparam int POS_WGT      = POS_DIV_OUT + 1;
   localparam int PIPE_LAT     = POS_DIV_OUT + 4;

   // delay line lengths and taps
   localparam int SIDE_LEN = POS_DIV_OUT - 1;
   localparam int T_TAP    = POS_VEC_OUT - 2;
   localparam int C_LEN    = POS_SQRT_OUT - 1;
   localparam int S_LEN    = POS_SIN_OUT - POS_SQRT_OUT;

   // fixed-point constants
   localparam logic [61:0]        Q60_ONE     = 62'(1) << 60;
   localparam logic signed [38:0] Q30_HALF_PI = 39'sd1686629713;
   localparam logic signed [38:0] Q30_PI      = 39'sd3373259426;
   localparam logic signed [33:0] Q30_GAIN_INV = 34'sd652032874;
   localparam logic signed [46:0] W_LERP_SUM  = 47'sd1073741824;

   // item data carried alongside the angle datapath
   typedef struct packed {
      logic [3:0][15:0] a;
      logic [3:0][16:0] bn;
      logic [15:0]      t;
      logic             lerp;
   } side_type;

   // atan(2^-i) in Q30
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         5'd24: v = 30'h0000003F;
         5'd25: v = 30'h0000001F;
         5'd26: v = 30'h0000000F;
         5'd27: v = 30'h00000008;
         5'd28: v = 30'h00000004;
         5'd29: v = 30'h00000002;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> src/qslerp_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on qslerp_pkg
`default_nettype none

module qslerp_isqrt import qslerp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [60:0] radicand,
   output logic      [30:0] root
);

   logic [61:0] rem_ff [ISQRT_LAT];
   logic [61:0] res_ff [ISQRT_LAT];

   for (genvar k = 0; k < ISQRT_LAT; k++) begin : g_step
      localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
      logic [61:0] rem_prev, res_prev, trial, rem_in, res_in;

      if (k == 0) begin : g_first
         assign rem_prev = {1'b0, radicand};
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      // trial subtract of the next root bit
      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[ISQRT_LAT-1][30:0];

endmodule

`default_nettype wire

>>> src/qslerp_cordic_vec.sv
// pipelined cordic in vectoring mode, gives the angle of (x, y) in Q30
// depends on qslerp_pkg
`default_nettype none

module qslerp_cordic_vec import qslerp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [33:0] x_start,
   input  wire logic signed [33:0] y_start,
   output logic signed      [33:0] theta
);

   logic signed [33:0] x_ff [VEC_STEPS];
   logic signed [33:0] y_ff [VEC_STEPS];
   logic signed [33:0] z_ff [VEC_STEPS];

   for (genvar i = 0; i < VEC_STEPS; i++) begin : g_iter
      logic signed [33:0] xp, yp, zp, dx, dy, ang, x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign xp = x_start;
         assign yp = y_start;
         assign zp = '0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      // rotate towards the x axis
      always_comb begin
         dx  = yp >>> i;
         dy  = xp >>> i;
         ang = $signed({4'b0, atan_q30(5'(i))});
         if (yp > 34'sd0) begin
            x_in = xp + dx;
            y_in = yp - dy;
            z_in = zp + ang;
         end else begin
            x_in = xp - dx;
            y_in = yp + dy;
            z_in = zp - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign theta = z_ff[VEC_STEPS-1];

endmodule

`default_nettype wire

>>> src/qslerp_cordic_sin.sv
// pipelined cordic sine: quadrant fold stage then rotation stages, Q30
// depends on qslerp_pkg
`default_nettype none

module qslerp_cordic_sin import qslerp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [36:0] angle,
   output logic signed      [33:0] sine
);

   logic signed [38:0] fold_ff;
   logic signed [38:0] fold_in;
   logic signed [38:0] fold_a;
   logic signed [38:0] ang_w;

   // fold into [-pi/2, pi/2], both folds checked in turn
   always_comb begin
      ang_w  = 39'(angle);
      fold_a = (ang_w > Q30_HALF_PI) ? (Q30_PI - ang_w) : ang_w;
      fold_in = (fold_a < -Q30_HALF_PI) ? (-Q30_PI - fold_a) : fold_a;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff <= fold_in;
      end
   end

   logic signed [33:0] x_ff [SIN_STEPS];
   logic signed [33:0] y_ff [SIN_STEPS];
   logic signed [38:0] z_ff [SIN_STEPS];

   for (genvar i = 0; i < SIN_STEPS; i++) begin : g_iter
      logic signed [33:0] xp, yp, dx, dy, x_in, y_in;
      logic signed [38:0] zp, ang, z_in;

      if (i == 0) begin : g_first
         assign xp = Q30_GAIN_INV;
         assign yp = '0;
         assign zp = fold_ff;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      // rotate by the residual angle
      always_comb begin
         dx  = yp >>> i;
         dy  = xp >>> i;
         ang = $signed({9'b0, atan_q30(5'(i))});
         if (zp >= 39'sd0) begin
            x_in = xp - dx;
            y_in = yp + dy;
            z_in = zp - ang;
         end else begin
            x_in = xp + dx;
            y_in = yp - dy;
            z_in = zp + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign sine = y_ff[SIN_STEPS-1];

endmodule

`default_nettype wire

>>> src/qslerp_div.sv
// pipelined restoring divider for the slerp weights: sign(n) * |n| * 2^30 / d
// depends on qslerp_pkg
`default_nettype none

module qslerp_div import qslerp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [33:0] num,
   input  wire logic        [30:0] den,
   output logic signed      [46:0] quot
);

   logic        neg0_ff;
   logic [30:0] den0_ff;
   logic [63:0] rem0_ff;
   logic [33:0] mag_w;

   // magnitude, divisor guard and scaled numerator
   always_comb begin
      mag_w = num[33] ? 34'(-num) : 34'(num);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff <= num[33];
         den0_ff <= (den == '0) ? 31'd1 : den;
         rem0_ff <= {mag_w, 30'b0};
      end
   end

   logic                 neg_ff [DIV_STEPS];
   logic [30:0]          den_ff [DIV_STEPS];
   logic [63:0]          rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_bit
      localparam int B = DIV_STEPS - 1 - j;
      logic                 neg_p;
      logic [30:0]          den_p;
      logic [63:0]          rem_p, rem_in;
      logic [DIV_STEPS-1:0] q_p, q_in;
      logic [76:0]          dshift;

      if (j == 0) begin : g_first
         assign neg_p = neg0_ff;
         assign den_p = den0_ff;
         assign rem_p = rem0_ff;
         assign q_p   = '0;
      end else begin : g_next
         assign neg_p = neg_ff[j-1];
         assign den_p = den_ff[j-1];
         assign rem_p = rem_ff[j-1];
         assign q_p   = q_ff[j-1];
      end

      // one quotient bit
      always_comb begin
         dshift = 77'(den_p) << B;
         if (77'(rem_p) >= dshift) begin
            rem_in = 64'(77'(rem_p) - dshift);
            q_in   = q_p | (DIV_STEPS'(1) << B);
         end else begin
            rem_in = rem_p;
            q_in   = q_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[j] <= neg_p;
            den_ff[j] <= den_p;
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
         end
      end
   end

   // restore the sign
   logic signed [46:0] quot_ff;
   logic signed [46:0] quot_in;

   always_comb begin
      quot_in = $signed({1'b0, q_ff[DIV_STEPS-1]});
      if (neg_ff[DIV_STEPS-1]) begin
         quot_in = -quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

>>> src/quaternion_slerp_core.sv
// Quaternion slerp core: takes one pair of Q2.14 quaternions and a blend factor per cycle
// while no result is held and returns the interpolated, saturated quaternion. It is
// fully pipelined (dot product, square root, vectoring cordic, angle scaling, two sine
// cordics, two restoring dividers, weighted sum), so it can accept one transfer every
// cycle while no result is held; items pass 31 root, 60 cordic and 46 divider stages.
// When a result is held at the output the whole pipeline freezes together. The lerp
// threshold register may be written at any time but takes effect per item at the
// second stage. Depends on qslerp_pkg, its submodules and the assertion macro header.
`default_nettype none

module quaternion_slerp_core import qslerp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend (16 bits each, lowest first)
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [143:0] req_tdata,
   // q_x, q_y, q_z, q_w (16 bits each, lowest first)
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [14:0]  csr_wr_data
);

   localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;

   logic                pipe_en;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic [14:0]         thr_ff, thr_in;

   // whole pipeline advances unless a result waits
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   // valid line and threshold register
   always_comb begin
      vld_in = pipe_en ? {vld_ff[PIPE_LAT-2:0], req_tvalid} : vld_ff;
      thr_in = csr_wr_en ? csr_wr_data : thr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= 15'd2;
      end else begin
         vld_ff <= vld_in;
         thr_ff <= thr_in;
      end
   end

   // stage 1: the four products
   logic signed [15:0] a1_ff [4];
   logic signed [15:0] b1_ff [4];
   logic signed [31:0] p1_ff [4];
   logic signed [15:0] t1_ff;
   logic signed [15:0] a1_in [4];
   logic signed [15:0] b1_in [4];
   logic signed [31:0] p1_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a1_in[k] = req_tdata[16*k +: 16];
         b1_in[k] = req_tdata[64 + 16*k +: 16];
         p1_in[k] = a1_in[k] * b1_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         p1_ff <= p1_in;
         t1_ff <= req_tdata[143:128];
      end
   end

   // stage 2: dot product, shorter arc, lerp decision
   side_type           side2_ff, side2_in;
   logic [30:0]        c2_ff, c2_in;
   logic signed [33:0] dot_w, absdot_w;
   logic signed [35:0] diff_w, thr_w;
   logic signed [16:0] bx_w [4];

   always_comb begin
      dot_w    = 34'(p1_ff[0]) + 34'(p1_ff[1]) + 34'(p1_ff[2]) + 34'(p1_ff[3]);
      absdot_w = dot_w[33] ? -dot_w : dot_w;
      diff_w   = 36'sd268435456 - 36'(absdot_w);
      thr_w    = $signed({7'b0, thr_ff, 14'b0});
      for (int k = 0; k < 4; k++) begin
         bx_w[k] = 17'(b1_ff[k]);
         side2_in.a[k]  = a1_ff[k];
         side2_in.bn[k] = dot_w[33] ? -bx_w[k] : bx_w[k];
      end
      side2_in.t    = t1_ff;
      side2_in.lerp = diff_w <= thr_w;
      c2_in         = {absdot_w[28:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side2_ff <= side2_in;
         c2_ff    <= c2_in;
      end
   end

   // stage 3: one minus cosine squared
   logic [60:0] n3_ff;
   logic [61:0] csq_w;

   assign csq_w = c2_ff * c2_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         n3_ff <= 61'(Q60_ONE - csq_w);
      end
   end

   // delay lines for item data, cosine and sine of theta
   side_type    side_ff   [SIDE_LEN];
   logic [30:0] c_line_ff [C_LEN];
   logic [30:0] s_line_ff [S_LEN];
   logic [30:0] root_w;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side_ff[0]   <= side2_ff;
         c_line_ff[0] <= c2_ff;
         s_line_ff[0] <= root_w;
         for (int j = 1; j < SIDE_LEN; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         for (int j = 1; j < C_LEN; j++) begin
            c_line_ff[j] <= c_line_ff[j-1];
         end
         for (int j = 1; j < S_LEN; j++) begin
            s_line_ff[j] <= s_line_ff[j-1];
         end
      end
   end

   // sine of theta
   qslerp_isqrt u_isqrt (
      .clock    (clock),
      .en       (pipe_en),
      .radicand (n3_ff),
      .root     (root_w)
   );

   // theta
   logic signed [33:0] theta_w;

   qslerp_cordic_vec u_vec (
      .clock   (clock),
      .en      (pipe_en),
      .x_start ($signed({3'b0, c_line_ff[C_LEN-1]})),
      .y_start ($signed({3'b0, root_w})),
      .theta   (theta_w)
   );

   // scaled angles (1 - t) theta and t theta
   logic signed [16:0] tq_w, omt_w;
   logic signed [50:0] prod0_w, prod1_w;
   logic signed [36:0] ang0_ff, ang1_ff;

   always_comb begin
      tq_w    = 17'($signed(side_ff[T_TAP].t));
      omt_w   = 17'sd16384 - tq_w;
      prod0_w = omt_w * theta_w;
      prod1_w = tq_w * theta_w;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ang0_ff <= prod0_w[50:14];
         ang1_ff <= prod1_w[50:14];
      end
   end

   // sines of the scaled angles
   logic signed [33:0] sin0_w, sin1_w;

   qslerp_cordic_sin u_sin0 (
      .clock (clock),
      .en    (pipe_en),
      .angle (ang0_ff),
      .sine  (sin0_w)
   );

   qslerp_cordic_sin u_sin1 (
      .clock (clock),
      .en    (pipe_en),
      .angle (ang1_ff),
      .sine  (sin1_w)
   );

   // slerp weights
   logic signed [46:0] q0_w, q1_w;

   qslerp_div u_div0 (
      .clock (clock),
      .en    (pipe_en),
      .num   (sin0_w),
      .den   (s_line_ff[S_LEN-1]),
      .quot  (q0_w)
   );

   qslerp_div u_div1 (
      .clock (clock),
      .en    (pipe_en),
      .num   (sin1_w),
      .den   (s_line_ff[S_LEN-1]),
      .quot  (q1_w)
   );

   // weight select: linear or spherical
   side_type           sd_w;
   logic signed [16:0] tw_w, omtw_w;
   logic signed [46:0] w0_ff, w1_ff, w0_in, w1_in;
   logic               wl_ff;
   logic signed [15:0] a4_ff  [4];
   logic signed [16:0] bn4_ff [4];

   always_comb begin
      sd_w   = side_ff[SIDE_LEN-1];
      tw_w   = 17'($signed(sd_w.t));
      omtw_w = 17'sd16384 - tw_w;
      if (sd_w.lerp) begin
         w0_in = $signed({{14{omtw_w[16]}}, omtw_w, 16'b0});
         w1_in = $signed({{15{sd_w.t[15]}}, sd_w.t, 16'b0});
      end else begin
         w0_in = q0_w;
         w1_in = q1_w;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         w0_ff <= w0_in;
         w1_ff <= w1_in;
         wl_ff <= sd_w.lerp;
         for (int k = 0; k < 4; k++) begin
            a4_ff[k]  <= sd_w.a[k];
            bn4_ff[k] <= sd_w.bn[k];
         end
      end
   end

   // weighted products
   logic signed [62:0] m0_ff [4];
   logic signed [63:0] m1_ff [4];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < 4; k++) begin
            m0_ff[k] <= w0_ff * a4_ff[k];
            m1_ff[k] <= w1_ff * bn4_ff[k];
         end
      end
   end

   // round, shift and saturate
   logic signed [65:0] acc_w [4];
   logic signed [35:0] sh_w  [4];
   logic [15:0]        q_ff  [4];
   logic [15:0]        q_in  [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         acc_w[k] = 66'(m0_ff[k]) + 66'(m1_ff[k]) + ROUND_HALF;
         sh_w[k]  = acc_w[k][65:30];
         priority if (sh_w[k] > 36'sd32767) begin
            q_in[k] = 16'h7FFF;
         end else if (sh_w[k] < -36'sd32768) begin
            q_in[k] = 16'h8000;
         end else begin
            q_in[k] = sh_w[k][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         q_ff <= q_in;
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_LAT-1];
   assign rsp_tdata  = {q_ff[3], q_ff[2], q_ff[1], q_ff[0]};

   // checks
   `include "quaternion_slerp_core_assert.svh"

   `QSC_ASSERT_NEXT(a_stall_freeze, clock, reset, !pipe_en, $stable(vld_ff), "valid line moved during stall")
   `QSC_ASSERT_NEXT(a_accept_enter, clock, reset, req_tvalid && req_tready, vld_ff[0], "accepted transfer not in first stage")
   `QSC_ASSERT_IMPLY(a_lerp_sum, clock, reset, vld_ff[POS_WGT] && wl_ff, (w0_ff + w1_ff) == W_LERP_SUM, "linear weights do not sum to one")

endmodule

`default_nettype wire
